// ----- rtl/scalar_keyframe_interpolator_unit_defines.svh -----
// Assertion macros shared by the keyframe interpolator RTL.
// Plain text header; no dependencies. Expects clk and rst_n in scope.
`ifndef SCALAR_KEYFRAME_INTERPOLATOR_UNIT_DEFINES_SVH
`define SCALAR_KEYFRAME_INTERPOLATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define SKIU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKIU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/skiu_pkg.sv -----
// Shared widths and codes for the scalar keyframe interpolator.
// No dependencies.
package skiu_pkg;

    localparam int TIME_W  = 32;
    localparam int VALUE_W = 32;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 7;
    localparam int FRAC_W  = 16;

    typedef logic [REQ_W-1:0]  req_code_t;
    typedef logic [STAT_W-1:0] status_t;

    // request codes
    localparam req_code_t REQ_APPEND = 2'd0;
    localparam req_code_t REQ_CLEAR  = 2'd1;
    localparam req_code_t REQ_SAMPLE = 2'd2;

    // status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_ORDER = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

endpackage

// ----- rtl/skiu_req_if.sv -----
// Request channel: valid/ready handshake carrying one request word.
// Depends on skiu_pkg.
interface skiu_req_if;
    logic                            valid;
    logic                            ready;
    logic [skiu_pkg::REQ_W-1:0]      req_type;
    logic [skiu_pkg::TIME_W-1:0]     time_in;
    logic signed [skiu_pkg::VALUE_W-1:0] key_value_in;

    modport source (output valid, output req_type, output time_in, output key_value_in,
                    input ready);
    modport sink   (input valid, input req_type, input time_in, input key_value_in,
                    output ready);
endinterface

// ----- rtl/skiu_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result word.
// Depends on skiu_pkg.
interface skiu_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [skiu_pkg::VALUE_W-1:0] sample_value;
    logic [skiu_pkg::STAT_W-1:0]         status;
    logic [skiu_pkg::CNT_W-1:0]          key_count_out;

    modport source (output valid, output sample_value, output status, output key_count_out,
                    input ready);
    modport sink   (input valid, input sample_value, input status, input key_count_out,
                    output ready);
endinterface

// ----- rtl/skiu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module skiu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/skiu_div.sv -----
// Restoring divider for the Q0.16 interpolation fraction, one bit a cycle.
// Requires num < den. Depends on skiu_pkg.
module skiu_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [skiu_pkg::TIME_W-1:0]    num,
    input  logic [skiu_pkg::TIME_W-1:0]    den,
    output logic                           done,
    output logic [skiu_pkg::FRAC_W-1:0]    quot
);
    localparam int TW  = skiu_pkg::TIME_W;
    localparam int QW  = skiu_pkg::FRAC_W;
    localparam int SW  = $clog2(QW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] step_reg, step_next;
    logic [TW-1:0] rem_reg, rem_next;
    logic [TW-1:0] den_reg, den_next;
    logic [QW-1:0] quot_reg, quot_next;
    logic [TW:0]   shifted;
    logic [TW:0]   diff;
    logic          fits;

    // one trial subtraction per cycle
    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        diff      = shifted - {1'b0, den_reg};
        fits      = (shifted >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = SW'(QW);
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[TW-1:0] : shifted[TW-1:0];
            quot_next = {quot_reg[QW-2:0], fits};
            step_next = step_reg - SW'(1);
            if (step_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

// ----- rtl/scalar_keyframe_interpolator_unit.sv -----
// Scalar keyframe interpolator: keyframe table in RAM plus a lookup sequencer.
//
// Channels: req (sink) takes one request word: append a keyframe, clear the
// table, or sample at a time. rsp (source) returns exactly one word per
// request: the sample value (zero unless a sample succeeded), a status code
// and the key count after the request.
// Flow: append, clear and failed samples go from accept to S_DONE and
// then to the output register. A sample scans the table in RAM one key a
// cycle, stopping at the first key not earlier than the query or at the
// last key; an exact or end match finishes there, while an interpolation
// runs the serial divider, one multiply stage and one add stage. The worst
// case is set by the RAM scan and the divider.
// One request is in flight at a time; req.ready is high while idle, and a
// new word may be taken while the previous response still waits.
// Reset empties the table (count and order fault cleared); RAM contents are
// left as they are. If rsp.ready stays low, the finished response is held
// and the unit waits before posting the next one.
// Depends on skiu_pkg, skiu_req_if, skiu_rsp_if, skiu_ram, skiu_div and the
// assertion macro header.
`include "scalar_keyframe_interpolator_unit_defines.svh"

module scalar_keyframe_interpolator_unit #(
    parameter int MAX_KEYS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    skiu_req_if.sink   req,
    skiu_rsp_if.source rsp
);
    localparam int TW = skiu_pkg::TIME_W;
    localparam int VW = skiu_pkg::VALUE_W;
    localparam int QW = skiu_pkg::FRAC_W;
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int PW = VW + 1 + QW + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_KEYS);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          fault_reg, fault_next;
    logic          out_valid_reg, out_valid_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [TW-1:0] last_t_reg, last_t_next;
    logic [TW-1:0] q_time_reg, q_time_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic [TW-1:0] prev_t_reg, prev_t_next;
    logic [VW-1:0] prev_v_reg, prev_v_next;
    logic [VW-1:0] vn_reg, vn_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [VW-1:0] res_value_reg, res_value_next;
    skiu_pkg::status_t res_status_reg, res_status_next;
    logic [VW-1:0] out_value_reg, out_value_next;
    skiu_pkg::status_t out_status_reg, out_status_next;
    logic [skiu_pkg::CNT_W-1:0] out_count_reg, out_count_next;

    logic          req_acc;
    logic          ram_we;
    logic          ram_re;
    logic [TW+VW-1:0] ram_rdata;
    logic [TW-1:0] rd_t;
    logic [VW-1:0] rd_v;
    logic          div_start;
    logic          div_done;
    logic [QW-1:0] div_quot;
    logic [TW-1:0] div_num;
    logic [TW-1:0] div_den;
    logic signed [VW:0] v_diff;

    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign rd_t      = ram_rdata[TW+VW-1:VW];
    assign rd_v      = ram_rdata[VW-1:0];
    assign ram_we    = req_acc && (req.req_type == skiu_pkg::REQ_APPEND)
                       && (count_reg < MAX_CNT);
    assign ram_re    = (state_reg == S_SCAN);
    assign div_num   = q_time_reg - prev_t_reg;
    assign div_den   = rd_t - prev_t_reg;
    assign v_diff    = $signed({vn_reg[VW-1], vn_reg}) - $signed({prev_v_reg[VW-1], prev_v_reg});

    skiu_ram #(
        .WIDTH (TW + VW),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({req.time_in, req.key_value_in}),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    skiu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // request sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        fault_next      = fault_reg;
        chk_vld_next    = chk_vld_reg;
        last_t_next     = last_t_reg;
        q_time_next     = q_time_reg;
        rd_addr_next    = rd_addr_reg;
        chk_idx_next    = chk_idx_reg;
        prev_t_next     = prev_t_reg;
        prev_v_next     = prev_v_reg;
        vn_next         = vn_reg;
        prod_next       = prod_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        div_start       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    res_value_next  = '0;
                    res_status_next = skiu_pkg::ST_OK;
                    state_next      = S_DONE;
                    case (req.req_type)
                        skiu_pkg::REQ_APPEND:
                        begin
                            if (count_reg >= MAX_CNT)
                            begin
                                res_status_next = skiu_pkg::ST_FULL;
                            end
                            else
                            begin
                                if ((count_reg != '0) && (req.time_in <= last_t_reg))
                                begin
                                    fault_next = 1'b1;
                                end
                                last_t_next = req.time_in;
                                count_next  = count_reg + CW'(1);
                                if (fault_next)
                                begin
                                    res_status_next = skiu_pkg::ST_ORDER;
                                end
                            end
                        end
                        skiu_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            fault_next = 1'b0;
                        end
                        skiu_pkg::REQ_SAMPLE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = skiu_pkg::ST_EMPTY;
                            end
                            else if (fault_reg)
                            begin
                                res_status_next = skiu_pkg::ST_ORDER;
                            end
                            else
                            begin
                                q_time_next  = req.time_in;
                                rd_addr_next = '0;
                                chk_vld_next = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // read one key a cycle; check the key read last cycle
                rd_addr_next = rd_addr_reg + AW'(1);
                chk_idx_next = rd_addr_reg;
                chk_vld_next = 1'b1;
                if (chk_vld_reg)
                begin
                    if (q_time_reg <= rd_t)
                    begin
                        if ((chk_idx_reg == '0) || (q_time_reg == rd_t))
                        begin
                            res_value_next = rd_v;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            vn_next    = rd_v;
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    else if (CW'(chk_idx_reg) == (count_reg - CW'(1)))
                    begin
                        res_value_next = rd_v;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        prev_t_next = rd_t;
                        prev_v_next = rd_v;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = PW'(v_diff * $signed({1'b0, div_quot}));
                state_next = S_ADD;
            end
            S_ADD:
            begin
                // floor of product / 2^16, low bits only
                res_value_next = prev_v_reg + prod_reg[QW+VW-1:QW];
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_DONE) && (!out_valid_reg || rsp.ready))
        begin
            out_valid_next  = 1'b1;
            out_value_next  = res_value_reg;
            out_status_next = res_status_reg;
            out_count_next  = skiu_pkg::CNT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            chk_vld_reg   <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_t_reg     <= last_t_next;
        q_time_reg     <= q_time_next;
        rd_addr_reg    <= rd_addr_next;
        chk_idx_reg    <= chk_idx_next;
        prev_t_reg     <= prev_t_next;
        prev_v_reg     <= prev_v_next;
        vn_reg         <= vn_next;
        prod_reg       <= prod_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.sample_value  = out_value_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.key_count_out = out_count_reg;

    // checks
    `SKIU_ASSERT_IMP(a_err_value_zero, rsp.valid && (rsp.status != skiu_pkg::ST_OK),
        rsp.sample_value == '0, "error response carries a nonzero value")
    `SKIU_ASSERT_NXT(a_full_keeps_count,
        req_acc && (req.req_type == skiu_pkg::REQ_APPEND) && (count_reg == MAX_CNT),
        $stable(count_reg), "append to a full table changed the count")
    `SKIU_ASSERT_IMP(a_div_done_in_div, div_done, state_reg == S_DIV,
        "divider finished outside the divide step")
    `SKIU_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= MAX_CNT,
        "key count beyond table size")
endmodule

// ----- tb/scalar_keyframe_interpolator_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for scalar_keyframe_interpolator_unit: directed and random
// append/clear/sample traffic with random idling on both channels.
// Depends on skiu_pkg, skiu_req_if, skiu_rsp_if and the unit itself.
module scalar_keyframe_interpolator_unit_tb;

    localparam int TW = skiu_pkg::TIME_W;
    localparam int VW = skiu_pkg::VALUE_W;
    localparam int CW = skiu_pkg::CNT_W;
    localparam int FW = skiu_pkg::FRAC_W;

    localparam int                 TABLE_DEPTH  = 64;
    localparam int                 RANDOM_ITEMS = 1250;
    localparam int                 CYCLE_LIMIT  = 1_000_000;
    localparam int                 DRAIN_CYCLES = 120;
    localparam int                 MAX_REPORTS  = 100;
    localparam skiu_pkg::req_code_t REQ_UNUSED  = 2'd3;
    localparam logic [31:0]        TIME_MAX     = 32'hFFFF_FFFF;
    localparam logic signed [31:0] VALUE_MIN    = 32'sh8000_0000;
    localparam logic signed [31:0] VALUE_MAX    = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [VW-1:0] sample_value;
        skiu_pkg::status_t    status;
        logic [CW-1:0]        key_count;
    } keyframe_reply_t;

    // Tracks the keyframe table and queues the reply each request should get
    class keyframe_table_tracker;
        logic [TW-1:0]         key_time [TABLE_DEPTH];
        logic signed [VW-1:0]  key_value [TABLE_DEPTH];
        int unsigned           key_total;
        bit                    order_fault;
        keyframe_reply_t       expected_replies [$];
        int                    mismatch_count;

        // piecewise linear lookup; table is non-empty and ordered here
        function logic signed [VW-1:0] lookup_value(logic [TW-1:0] t);
            longint span, offset, frac, delta, scaled;
            int unsigned i;
            if (t <= key_time[0])
                return key_value[0];
            if (t >= key_time[key_total-1])
                return key_value[key_total-1];
            for (i = 1; i < key_total; i++)
            begin
                if (t <= key_time[i])
                begin
                    if (t == key_time[i])
                        return key_value[i];
                    span   = longint'(key_time[i]) - longint'(key_time[i-1]);
                    offset = longint'(t) - longint'(key_time[i-1]);
                    frac   = (offset <<< FW) / span;
                    delta  = longint'(key_value[i]) - longint'(key_value[i-1]);
                    scaled = delta * frac;
                    // arithmetic shift of a signed product floors toward minus infinity
                    return VW'(longint'(key_value[i-1]) + (scaled >>> FW));
                end
            end
            return key_value[key_total-1];
        endfunction

        function keyframe_reply_t predict_reply(skiu_pkg::req_code_t code, logic [TW-1:0] t,
                                                logic signed [VW-1:0] v);
            keyframe_reply_t reply;
            reply = '0;
            reply.status = skiu_pkg::ST_OK;
            case (code)
                skiu_pkg::REQ_APPEND:
                begin
                    if (key_total >= TABLE_DEPTH)
                        reply.status = skiu_pkg::ST_FULL;
                    else
                    begin
                        if (key_total > 0 && t <= key_time[key_total-1])
                            order_fault = 1'b1;
                        key_time[key_total]  = t;
                        key_value[key_total] = v;
                        key_total++;
                        reply.status = order_fault ? skiu_pkg::ST_ORDER : skiu_pkg::ST_OK;
                    end
                end
                skiu_pkg::REQ_CLEAR:
                begin
                    key_total   = 0;
                    order_fault = 1'b0;
                end
                skiu_pkg::REQ_SAMPLE:
                begin
                    if (key_total == 0)
                        reply.status = skiu_pkg::ST_EMPTY;
                    else if (order_fault)
                        reply.status = skiu_pkg::ST_ORDER;
                    else
                        reply.sample_value = lookup_value(t);
                end
                default: ;
            endcase
            reply.key_count = CW'(key_total);
            return reply;
        endfunction

        function void note_request(skiu_pkg::req_code_t code, logic [TW-1:0] t,
                                   logic signed [VW-1:0] v);
            expected_replies.insert(expected_replies.size(), predict_reply(code, t, v));
        endfunction

        function void flag(string field, longint want, longint got);
            if (mismatch_count < MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        endfunction

        function void check_reply(keyframe_reply_t got);
            keyframe_reply_t want;
            if (expected_replies.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: unexpected reply: expected none, %s %0d status %0d count %0d",
                             $time, "got value", got.sample_value, got.status, got.key_count);
                mismatch_count++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.sample_value !== want.sample_value)
                flag("sample_value", longint'(want.sample_value), longint'(got.sample_value));
            if (got.status !== want.status)
                flag("status", longint'(want.status), longint'(got.status));
            if (got.key_count !== want.key_count)
                flag("key_count_out", longint'(want.key_count), longint'(got.key_count));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   items_sent;
    bit   req_idle_on;
    bit   rsp_idle_on;
    logic [TW-1:0] loaded_times [$];

    keyframe_table_tracker table_tracker = new();

    skiu_req_if req_ch ();
    skiu_rsp_if rsp_ch ();

    scalar_keyframe_interpolator_unit #(
        .MAX_KEYS (TABLE_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("scalar_keyframe_interpolator_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic int idle_cycles(bit on);
        return on ? $urandom_range(0, 14) : 0;
    endfunction

    function automatic longint unsigned rand_below(longint unsigned limit);
        longint unsigned r;
        r = {$urandom(), $urandom()};
        return r % limit;
    endfunction

    function automatic logic signed [VW-1:0] draw_key_value(int mode,
                                                            logic signed [VW-1:0] prior);
        case (mode)
            0: return $urandom();
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            2: return int'($urandom_range(0, 2000)) - 1000;
            default: return ($urandom_range(0, 3) == 0) ? $urandom() : prior;
        endcase
    endfunction

    // query time near the loaded keys: on them, between, outside, or anywhere
    function automatic logic [TW-1:0] pick_query_time();
        int              last;
        int              i;
        longint unsigned lo;
        longint unsigned hi;
        if (loaded_times.size() == 0)
            return $urandom();
        last = loaded_times.size() - 1;
        case ($urandom_range(0, 7))
            0: return loaded_times[$urandom_range(0, last)];
            1, 2:
            begin
                if (last == 0)
                    return loaded_times[0];
                i  = $urandom_range(1, last);
                lo = loaded_times[i-1];
                hi = loaded_times[i];
                if (hi > lo + 1)
                    return TW'(lo + 1 + rand_below(hi - lo - 1));
                return TW'(hi);
            end
            3:
            begin
                lo = loaded_times[0];
                return TW'(rand_below(lo + 1));
            end
            4:
            begin
                lo = loaded_times[last];
                return TW'(lo + rand_below(64'h1_0000_0000 - lo));
            end
            5:
                return loaded_times[$urandom_range(0, last)]
                       + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
            6: return $urandom();
            default: return $urandom_range(0, 1) ? 32'h0 : TIME_MAX;
        endcase
    endfunction

    // drive one request word and wait until it is taken
    task automatic send_request(skiu_pkg::req_code_t code, logic [TW-1:0] t,
                                logic [VW-1:0] v);
        int gap;
        if (items_sent % 40 == 0)
            req_idle_on = ($urandom_range(0, 3) != 0);
        gap = idle_cycles(req_idle_on);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= code;
        req_ch.time_in      <= t;
        req_ch.key_value_in <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        table_tracker.note_request(code, t, v);
        if (code != REQ_UNUSED)
            items_sent++;
    endtask

    // clear, then append n keys with rising times; optionally one key out of order
    task automatic load_keys(int n, bit with_fault);
        longint unsigned prev;
        longint unsigned room;
        longint unsigned cap;
        longint unsigned step;
        int              fault_at;
        int              value_mode;
        int              i;
        logic [TW-1:0]         t;
        logic signed [VW-1:0]  v;
        loaded_times.delete();
        value_mode = $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0: cap = 4;
            1: cap = 64'h1000;
            2: cap = 64'h10_0000;
            default: cap = 64'h1_0000_0000;
        endcase
        fault_at = (with_fault && n > 1) ? $urandom_range(1, n - 1) : 0;
        send_request(skiu_pkg::REQ_CLEAR, $urandom(), $urandom());
        prev = ($urandom_range(0, 3) == 0) ? 0 : rand_below(64'h1_0000_0000 - n);
        v = draw_key_value(value_mode, '0);
        loaded_times.insert(loaded_times.size(), TW'(prev));
        send_request(skiu_pkg::REQ_APPEND, TW'(prev), v);
        for (i = 1; i < n; i++)
        begin
            // leave room for every key still to come
            room = (64'hFFFF_FFFF - prev) / longint'(n - i);
            step = 1 + rand_below((room < cap) ? room : cap);
            v = draw_key_value(value_mode, v);
            if (i == fault_at)
                t = TW'(prev - rand_below(((prev < cap) ? prev : cap) + 1));
            else
            begin
                prev = prev + step;
                t = TW'(prev);
            end
            loaded_times.insert(loaded_times.size(), t);
            send_request(skiu_pkg::REQ_APPEND, t, v);
        end
    endtask

    task automatic probe_samples(int count);
        repeat (count) send_request(skiu_pkg::REQ_SAMPLE, pick_query_time(), $urandom());
    endtask

    // reply side: random stalls, check every accepted word
    initial
    begin : reply_sink
        keyframe_reply_t got;
        int              gap;
        int              replies_seen;
        replies_seen = 0;
        rsp_idle_on  = 1'b1;
        forever
        begin
            if (replies_seen % 40 == 0)
                rsp_idle_on = ($urandom_range(0, 3) != 0);
            gap = idle_cycles(rsp_idle_on);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            got.sample_value = rsp_ch.sample_value;
            got.status       = rsp_ch.status;
            got.key_count    = rsp_ch.key_count_out;
            table_tracker.check_reply(got);
            replies_seen++;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int n;
        int kind;
        items_sent   = 0;
        req_idle_on  = 1'b1;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= skiu_pkg::REQ_APPEND;
        req_ch.time_in      <= '0;
        req_ch.key_value_in <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table and the unused code
        send_request(skiu_pkg::REQ_SAMPLE, 32'h0, 32'h0);
        send_request(REQ_UNUSED, TIME_MAX, 32'hFFFF_FFFF);
        // three keys swinging between the value extremes
        send_request(skiu_pkg::REQ_APPEND, 32'h0000_0100, VALUE_MIN);
        send_request(skiu_pkg::REQ_APPEND, 32'h0001_0100, VALUE_MAX);
        send_request(skiu_pkg::REQ_APPEND, TIME_MAX, VALUE_MIN);
        send_request(skiu_pkg::REQ_SAMPLE, 32'h0, 32'h0);
        send_request(skiu_pkg::REQ_SAMPLE, 32'h0000_0100, 32'h0);
        send_request(skiu_pkg::REQ_SAMPLE, 32'h0000_0101, 32'h0);
        send_request(skiu_pkg::REQ_SAMPLE, 32'h0000_8100, 32'h0);
        send_request(skiu_pkg::REQ_SAMPLE, 32'h0001_0100, 32'h0);
        send_request(skiu_pkg::REQ_SAMPLE, 32'h8000_0000, 32'h0);
        send_request(skiu_pkg::REQ_SAMPLE, 32'hFFFF_FFFE, 32'h0);
        send_request(skiu_pkg::REQ_SAMPLE, TIME_MAX, 32'h0);
        // equal time, then an earlier one: order fault sticks until cleared
        send_request(skiu_pkg::REQ_APPEND, TIME_MAX, 32'h0);
        send_request(skiu_pkg::REQ_APPEND, 32'h0, 32'h0);
        send_request(skiu_pkg::REQ_SAMPLE, 32'h0000_8000, 32'h0);
        send_request(skiu_pkg::REQ_CLEAR, TIME_MAX, 32'hFFFF_FFFF);
        send_request(skiu_pkg::REQ_SAMPLE, 32'h0000_8000, 32'h0);
        // single key answers every query
        send_request(skiu_pkg::REQ_APPEND, 32'h0, 32'sd1234);
        send_request(skiu_pkg::REQ_SAMPLE, 32'h0, 32'h0);
        send_request(skiu_pkg::REQ_SAMPLE, 32'h5, 32'h0);
        send_request(skiu_pkg::REQ_SAMPLE, TIME_MAX, 32'h0);
        // fill to capacity, then appends are refused
        load_keys(TABLE_DEPTH, 1'b0);
        send_request(skiu_pkg::REQ_APPEND, TIME_MAX, VALUE_MAX);
        send_request(skiu_pkg::REQ_APPEND, 32'h0, VALUE_MIN);
        probe_samples(6);

        // random sequences: mostly ordered tables, some faults, some noise
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    send_request(skiu_pkg::req_code_t'($urandom_range(0, 3)),
                                 $urandom(), $urandom());
            else
            begin
                kind = $urandom_range(0, 5);
                if (kind == 0)
                    n = TABLE_DEPTH;
                else if (kind == 1)
                    n = $urandom_range(1, TABLE_DEPTH - 1);
                else
                    n = $urandom_range(1, 8);
                load_keys(n, $urandom_range(0, 9) == 0);
                if (n == TABLE_DEPTH)
                    repeat ($urandom_range(1, 3))
                        send_request(skiu_pkg::REQ_APPEND, $urandom(), $urandom());
                probe_samples($urandom_range(2, 12));
            end
        end
        req_ch.valid <= 1'b0;

        // drain
        while (table_tracker.expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (table_tracker.mismatch_count == 0 && table_tracker.expected_replies.size() == 0)
            $display("scalar_keyframe_interpolator_unit_tb: PASS");
        else
            $display("scalar_keyframe_interpolator_unit_tb: FAIL");
        $finish;
    end

endmodule
